>>> design/ica_pkg.sv
package ica_pkg;

  localparam int SAMPLE_W  = 32;
  localparam int SUM_W     = 48;
  localparam int CNT_W     = 16;
  localparam int NCH_CFG_W = 5;
  localparam int CH_OUT_W  = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_CHANNELS        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_CHANNEL = 2'd1;

  typedef struct packed {
    logic load;
    logic acc;
    logic div_start;
    logic out_load;
    logic cfg_wr;
  } ica_cmd_t;

  typedef struct packed {
    logic final_round;
    logic div_done;
    logic out_free;
  } ica_sts_t;

endpackage

>>> design/ica_div.sv
module ica_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ica_pkg::SUM_W-1:0]     dividend,
  input  logic [ica_pkg::CNT_W-1:0]     divisor,
  output logic                          done,
  output logic [ica_pkg::SAMPLE_W-1:0]  quotient
);
  import ica_pkg::*;

  localparam int STEP_W = $clog2(SAMPLE_W);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [CNT_W-1:0]    div_r, div_nxt;
  logic [CNT_W-1:0]    rem_r, rem_nxt;
  logic [SAMPLE_W-1:0] q_r, q_nxt;
  logic [CNT_W:0]      shifted;
  logic [CNT_W+1:0]    diff;
  logic                ge;

  // The quotient always fits in the sample width, so the upper part of the
  // dividend is already a valid partial remainder.
  assign shifted = {rem_r, q_r[SAMPLE_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, div_r};
  assign ge      = ~diff[CNT_W+1];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      div_nxt  = divisor;
      rem_nxt  = dividend[SUM_W-1:SAMPLE_W];
      q_nxt    = dividend[SAMPLE_W-1:0];
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
      q_nxt    = {q_r[SAMPLE_W-2:0], ge};
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(SAMPLE_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_r <= div_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

>>> design/ica_dp.sv
module ica_dp #(
  parameter int MAX_CHANNELS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [ica_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ica_pkg::CFG_DAT_W-1:0]  cfg_data,
  input  logic [ica_pkg::SAMPLE_W-1:0]   in_sample,
  input  ica_pkg::ica_cmd_t              cmd,
  output ica_pkg::ica_sts_t              sts,
  input  logic                           out_stall,
  output logic                           out_valid,
  output logic [ica_pkg::CH_OUT_W-1:0]   out_channel,
  output logic [ica_pkg::SAMPLE_W-1:0]   out_average,
  output logic                           out_last
);
  import ica_pkg::*;

  localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int NW_A  = $clog2(MAX_CHANNELS + 1);
  localparam int NW    = (NW_A > NCH_CFG_W) ? NW_A : NCH_CFG_W;

  logic [NCH_CFG_W-1:0]    nch_r;
  logic [CNT_W-1:0]        spc_r;
  logic [CH_W-1:0]         ch_r;
  logic [CNT_W-1:0]        round_r;
  logic [CH_W-1:0]         cur_ch_r;
  logic [SAMPLE_W-1:0]     sample_r;
  logic [SUM_W-1:0]        rd_data_r;
  logic                    rd_vld_r;
  logic [MAX_CHANNELS-1:0] sum_vld_r;
  logic [CH_W-1:0]         ch_hold_r;
  logic                    last_hold_r;
  logic                    out_valid_r;
  logic [CH_OUT_W-1:0]     out_channel_r;
  logic [SAMPLE_W-1:0]     out_average_r;
  logic                    out_last_r;

  logic [SUM_W-1:0]        sum_mem [MAX_CHANNELS];

  logic [NW-1:0]           eff_nch;
  logic [NW-1:0]           nch_ext;
  logic [CNT_W-1:0]        eff_cnt;
  logic [CH_W-1:0]         ch_sel;
  logic                    final_round;
  logic [SUM_W-1:0]        sum_nxt;
  logic [NW-1:0]           ch_inc;
  logic                    wrap;
  logic [CH_W+CH_OUT_W-1:0] ch_ext;
  logic                    div_done;
  logic [SAMPLE_W-1:0]     quotient;

  assign nch_ext = NW'(nch_r);
  assign eff_nch = (nch_ext == '0) ? NW'(1) :
                   (nch_ext > NW'(MAX_CHANNELS)) ? NW'(MAX_CHANNELS) : nch_ext;
  assign eff_cnt = (spc_r == '0) ? CNT_W'(1) : spc_r;
  assign ch_sel  = (NW'(ch_r) >= eff_nch) ? '0 : ch_r;

  assign final_round = ({1'b0, round_r} + 1'b1) >= {1'b0, eff_cnt};
  assign sum_nxt     = (rd_vld_r ? rd_data_r : '0) + SUM_W'(sample_r);
  assign ch_inc      = NW'(cur_ch_r) + 1'b1;
  assign wrap        = ch_inc >= eff_nch;
  assign ch_ext      = {{CH_OUT_W{1'b0}}, ch_hold_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nch_r     <= NCH_CFG_W'(1);
      spc_r     <= CNT_W'(1);
      ch_r      <= '0;
      round_r   <= '0;
      sum_vld_r <= '0;
    end else if (cmd.cfg_wr) begin
      case (cfg_index)
        REG_NUM_CHANNELS:        nch_r <= cfg_data[NCH_CFG_W-1:0];
        REG_SAMPLES_PER_CHANNEL: spc_r <= cfg_data;
        default:                 ;
      endcase
      if (cfg_index == REG_NUM_CHANNELS || cfg_index == REG_SAMPLES_PER_CHANNEL) begin
        ch_r      <= '0;
        round_r   <= '0;
        sum_vld_r <= '0;
      end
    end else if (cmd.acc) begin
      sum_vld_r[cur_ch_r] <= ~final_round;
      if (wrap) begin
        ch_r    <= '0;
        round_r <= final_round ? '0 : round_r + 1'b1;
      end else begin
        ch_r <= CH_W'(ch_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_r  <= in_sample;
      cur_ch_r  <= ch_sel;
      rd_data_r <= sum_mem[ch_sel];
      rd_vld_r  <= sum_vld_r[ch_sel];
    end
    if (cmd.acc) begin
      sum_mem[cur_ch_r] <= sum_nxt;
      ch_hold_r         <= cur_ch_r;
      last_hold_r       <= (ch_inc == eff_nch);
    end
  end

  ica_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (sum_nxt),
    .divisor  (eff_cnt),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_channel_r <= ch_ext[CH_OUT_W-1:0];
      out_average_r <= quotient;
      out_last_r    <= last_hold_r;
    end
  end

  assign sts.final_round = final_round;
  assign sts.div_done    = div_done;
  assign sts.out_free    = ~out_valid_r | ~out_stall;

  assign out_valid   = out_valid_r;
  assign out_channel = out_channel_r;
  assign out_average = out_average_r;
  assign out_last    = out_last_r;

`ifndef ASSERT_OFF
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("Result register overwritten while its request is still stalled.");

  a_round_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.acc) |-> ({1'b0, round_r} < {1'b0, eff_cnt}))
    else $error("Round count reached the block length.");

  a_div_after_final: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> (cmd.acc && final_round))
    else $error("Divider started outside the final round.");
`endif

endmodule

>>> design/ica_ctrl.sv
module ica_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  ica_pkg::ica_sts_t sts,
  output ica_pkg::ica_cmd_t cmd
);
  import ica_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ACC  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       idle;

  assign idle      = (state_r == S_IDLE);
  assign in_stall  = ~idle;
  assign cfg_ready = idle & ~in_valid;

  always_comb begin
    state_nxt     = state_r;
    cmd.load      = 1'b0;
    cmd.acc       = 1'b0;
    cmd.div_start = 1'b0;
    cmd.out_load  = 1'b0;
    cmd.cfg_wr    = cfg_valid & cfg_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (sts.final_round) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_accept_to_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_ACC))
    else $error("Accepted request did not move on to accumulation.");

  a_final_to_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC && sts.final_round) |=> (state_r == S_DIV))
    else $error("Final round did not start a division.");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> (state_r == S_DIV))
    else $error("Divider finished while the controller was not waiting for it.");
`endif

endmodule

>>> design/interleaved_channel_averager.sv
// Averages an interleaved sample stream per channel. Samples arrive for
// channels 0 to num_channels-1 in turn, each added into that channel's
// 48-bit sum. In the final round of a block, each channel's sample yields
// one result with the truncated mean of that block, the channel number and
// a last flag on the final channel, and the sum starts over. Each sample
// first reads its channel's sum from the sum memory, then adds to it and
// writes it back. A sample of the final round also runs through the 32 steps
// of the bit-serial divider. A finished result waits in an output register
// while the next sample is accepted. Any write to num_channels or
// samples_per_channel restarts the block with all sums at zero; the port
// takes writes only while no sample is in flight.
module interleaved_channel_averager #(
  parameter int MAX_CHANNELS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ica_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ica_pkg::CFG_DAT_W-1:0]  cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [ica_pkg::SAMPLE_W-1:0]   in_sample,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ica_pkg::CH_OUT_W-1:0]   out_channel,
  output logic [ica_pkg::SAMPLE_W-1:0]   out_average,
  output logic                           out_last
);
  import ica_pkg::*;

  ica_cmd_t cmd;
  ica_sts_t sts;

  ica_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ica_dp #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_sample   (in_sample),
    .cmd         (cmd),
    .sts         (sts),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_channel (out_channel),
    .out_average (out_average),
    .out_last    (out_last)
  );

endmodule
